@@ rtl/core/shamd_pkg.sv @@
`default_nettype none

package shamd_pkg;

    // Kind of a request after classification by the front end
    typedef enum logic [1:0] {
        ITEM_BYTE,
        ITEM_BYTE_END,
        ITEM_END
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  data;
    } item_t;

    // Front end to queue
    typedef struct packed {
        logic   push;
        item_t  item;
    } q_push_t;

    // Queue head to back end
    typedef struct packed {
        logic   valid;
        item_t  item;
    } q_head_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_ADD,
        ST_OUT
    } back_state_t;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN
    } pad_stage_t;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] LEN_FIELD_POS = 6'd56;
    localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

`default_nettype wire

@@ rtl/core/shamd_front.sv @@
`default_nettype none

module shamd_front (
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_data_byte,
    input  wire logic              s_byte_present,
    input  wire logic              s_end_of_message,
    input  wire logic              q_full,
    output shamd_pkg::q_push_t     q_push
);

    // Take requests whenever the queue has room
    assign s_ready = !q_full;

    // Requests with neither byte nor end do nothing and are dropped here
    always_comb begin
        q_push.push      = s_valid && !q_full && (s_byte_present || s_end_of_message);
        q_push.item.data = s_data_byte;
        priority if (s_byte_present && s_end_of_message) begin
            q_push.item.kind = shamd_pkg::ITEM_BYTE_END;
        end else if (s_byte_present) begin
            q_push.item.kind = shamd_pkg::ITEM_BYTE;
        end else begin
            q_push.item.kind = shamd_pkg::ITEM_END;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/shamd_queue.sv @@
`default_nettype none

module shamd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire shamd_pkg::q_push_t q_push,
    input  wire logic               q_pop,
    output logic                    q_full,
    output shamd_pkg::q_head_t      q_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

    shamd_pkg::item_t mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign q_full       = (count_reg == COUNT_FULL);
    assign q_head.valid = (count_reg != '0);
    assign q_head.item  = mem_reg[rd_ptr_reg];

    assign do_push = q_push.push && !q_full;
    assign do_pop  = q_pop && q_head.valid;

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= q_push.item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/shamd_back.sv @@
`default_nettype none

module shamd_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire shamd_pkg::q_head_t q_head,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [31:0]             m_digest_word,
    output logic [2:0]              m_word_index,
    output logic                    m_last_word
);

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    shamd_pkg::back_state_t state_reg, state_next;
    shamd_pkg::pad_stage_t  pad_stage_reg, pad_stage_next;
    logic        pad_active_reg, pad_active_next;
    logic        final_reg, final_next;
    logic [5:0]  pos_reg, pos_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic [2:0]  len_cnt_reg, len_cnt_next;
    logic [60:0] len_reg, len_next;
    logic [63:0] len_bits_reg, len_bits_next;
    logic [23:0] word_reg, word_next;
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];

    // Control decoded from the state
    logic        wr_en;
    logic [7:0]  wr_byte;
    logic        count_byte;
    logic        take_end;
    logic        pad_shift;
    logic        wr_last;
    logic        out_done;
    logic [60:0] len_after;

    // Round datapath
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] w_new;

    // Outputs of the sequencer
    always_comb begin
        q_pop      = 1'b0;
        wr_en      = 1'b0;
        wr_byte    = 8'h00;
        count_byte = 1'b0;
        take_end   = 1'b0;
        pad_shift  = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            shamd_pkg::ST_IDLE: begin
                if (q_head.valid) begin
                    q_pop = 1'b1;
                    unique case (q_head.item.kind)
                        shamd_pkg::ITEM_BYTE: begin
                            wr_en      = 1'b1;
                            wr_byte    = q_head.item.data;
                            count_byte = 1'b1;
                        end
                        shamd_pkg::ITEM_BYTE_END: begin
                            wr_en      = 1'b1;
                            wr_byte    = q_head.item.data;
                            count_byte = 1'b1;
                            take_end   = 1'b1;
                        end
                        shamd_pkg::ITEM_END: begin
                            take_end = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            shamd_pkg::ST_PAD: begin
                unique case (pad_stage_reg)
                    shamd_pkg::PAD_MARK: begin
                        wr_en   = 1'b1;
                        wr_byte = shamd_pkg::PAD_MARK_BYTE;
                    end
                    shamd_pkg::PAD_ZERO: begin
                        wr_en = (pos_reg != shamd_pkg::LEN_FIELD_POS);
                    end
                    shamd_pkg::PAD_LEN: begin
                        wr_en     = 1'b1;
                        wr_byte   = len_bits_reg[63:56];
                        pad_shift = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            shamd_pkg::ST_OUT: begin
                m_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign wr_last  = wr_en && (pos_reg == shamd_pkg::BLOCK_LAST_POS);
    assign out_done = m_valid && m_ready && m_last_word;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            shamd_pkg::ST_IDLE: begin
                if (wr_last) begin
                    state_next = shamd_pkg::ST_COMP;
                end else if (take_end) begin
                    state_next = shamd_pkg::ST_PAD;
                end
            end
            shamd_pkg::ST_PAD: begin
                if (wr_last) begin
                    state_next = shamd_pkg::ST_COMP;
                end
            end
            shamd_pkg::ST_COMP: begin
                if (round_reg == shamd_pkg::ROUND_LAST) begin
                    state_next = shamd_pkg::ST_ADD;
                end
            end
            shamd_pkg::ST_ADD: begin
                priority if (final_reg) begin
                    state_next = shamd_pkg::ST_OUT;
                end else if (pad_active_reg) begin
                    state_next = shamd_pkg::ST_PAD;
                end else begin
                    state_next = shamd_pkg::ST_IDLE;
                end
            end
            shamd_pkg::ST_OUT: begin
                if (out_done) begin
                    state_next = shamd_pkg::ST_IDLE;
                end
            end
            default: state_next = shamd_pkg::ST_IDLE;
        endcase
    end

    // Padding progress, message length and output index
    assign len_after = count_byte ? len_reg + 61'd1 : len_reg;

    always_comb begin
        pad_stage_next  = pad_stage_reg;
        pad_active_next = pad_active_reg;
        final_next      = final_reg;
        len_cnt_next    = len_cnt_reg;
        out_idx_next    = out_idx_reg;
        len_next        = len_after;
        len_bits_next   = len_bits_reg;
        if (take_end) begin
            pad_active_next = 1'b1;
            len_next        = '0;
            len_bits_next   = {len_after, 3'b000};
        end
        if (state_reg == shamd_pkg::ST_PAD) begin
            if (pad_stage_reg == shamd_pkg::PAD_MARK) begin
                pad_stage_next = shamd_pkg::PAD_ZERO;
            end
            if (pad_stage_reg == shamd_pkg::PAD_ZERO && !wr_en) begin
                pad_stage_next = shamd_pkg::PAD_LEN;
            end
        end
        if (pad_shift) begin
            len_bits_next = {len_bits_reg[55:0], 8'h00};
            len_cnt_next  = len_cnt_reg + 1'b1;
            if (len_cnt_reg == 3'd7) begin
                final_next = 1'b1;
            end
        end
        if (m_valid && m_ready) begin
            out_idx_next = out_idx_reg + 1'b1;
        end
        if (out_done) begin
            pad_stage_next  = shamd_pkg::PAD_MARK;
            pad_active_next = 1'b0;
            final_next      = 1'b0;
            len_cnt_next    = '0;
        end
    end

    // One compression round and the next schedule word
    always_comb begin
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + big_sigma1(v_reg[4]) + ch + shamd_pkg::ROUND_K[round_reg]
                + win_reg[0];
        t2    = big_sigma0(v_reg[0]) + maj;
        w_new = small_sigma1(win_reg[14]) + win_reg[9] + small_sigma0(win_reg[1])
                + win_reg[0];
    end

    // Block buffer, working variables and chaining words
    always_comb begin
        pos_next   = pos_reg;
        round_next = round_reg;
        word_next  = word_reg;
        win_next   = win_reg;
        v_next     = v_reg;
        chain_next = chain_reg;

        // byte insert: words enter the schedule window as they complete
        if (wr_en) begin
            pos_next  = pos_reg + 1'b1;
            word_next = {word_reg[15:0], wr_byte};
            if (pos_reg[1:0] == 2'b11) begin
                for (int j = 0; j < 15; j++) begin
                    win_next[j] = win_reg[j + 1];
                end
                win_next[15] = {word_reg, wr_byte};
            end
        end

        // block full: load working variables
        if (wr_last) begin
            round_next = '0;
            v_next     = chain_reg;
        end

        if (state_reg == shamd_pkg::ST_COMP) begin
            round_next = round_reg + 1'b1;
            for (int j = 0; j < 15; j++) begin
                win_next[j] = win_reg[j + 1];
            end
            win_next[15] = w_new;
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end

        if (state_reg == shamd_pkg::ST_ADD) begin
            for (int j = 0; j < 8; j++) begin
                chain_next[j] = chain_reg[j] + v_reg[j];
            end
        end

        if (out_done) begin
            chain_next = shamd_pkg::INIT_HASH;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= shamd_pkg::ST_IDLE;
            pad_stage_reg  <= shamd_pkg::PAD_MARK;
            pad_active_reg <= 1'b0;
            final_reg      <= 1'b0;
            pos_reg        <= '0;
            round_reg      <= '0;
            out_idx_reg    <= '0;
            len_cnt_reg    <= '0;
            len_reg        <= '0;
            chain_reg      <= shamd_pkg::INIT_HASH;
        end else begin
            state_reg      <= state_next;
            pad_stage_reg  <= pad_stage_next;
            pad_active_reg <= pad_active_next;
            final_reg      <= final_next;
            pos_reg        <= pos_next;
            round_reg      <= round_next;
            out_idx_reg    <= out_idx_next;
            len_cnt_reg    <= len_cnt_next;
            len_reg        <= len_next;
            chain_reg      <= chain_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        len_bits_reg <= len_bits_next;
        word_reg     <= word_next;
        win_reg      <= win_next;
        v_reg        <= v_next;
    end

    assign m_digest_word = chain_reg[out_idx_reg];
    assign m_word_index  = out_idx_reg;
    assign m_last_word   = (out_idx_reg == 3'd7);

    // A pop is only issued against a valid queue head
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_head.valid)
        else $error("pop from empty queue");

    // The add step only follows the last round
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == shamd_pkg::ST_ADD) |-> ($past(round_reg) == shamd_pkg::ROUND_LAST))
        else $error("chain update before round 63");

    // Length bytes always land in the last eight block positions
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == shamd_pkg::ST_PAD && pad_stage_reg == shamd_pkg::PAD_LEN)
        |-> (pos_reg[5:3] == 3'b111))
        else $error("length field misaligned");

    // Chaining words return to the initial values after a digest
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_done |=> (chain_reg[0] == shamd_pkg::INIT_HASH[0] && out_idx_reg == 3'd0))
        else $error("chain not reinitialized after digest");

endmodule

`default_nettype wire

@@ rtl/core/sha256_message_digest.sv @@
`default_nettype none
// SHA-256 streaming hash, one message byte per input request.
// Input channel s_*: each request holds s_data_byte, s_byte_present and
// s_end_of_message. A request with neither byte nor end is dropped. A request
// with only the end flag closes the message (hashing an empty message works).
// Requests go into a queue of QUEUE_DEPTH entries; s_ready is low only when
// it is full, so the sender keeps going while a digest waits on m_*.
// The back end takes one byte per cycle while idle, and each time a 64-byte
// block fills it runs 64 rounds and one chain add before taking more bytes.
// At the end of a message the padding is fed one byte a cycle, with one or
// two more block compressions, then the eight digest
// words come out on m_*, word_index 0 first, last_word on word 7, one per
// cycle while m_ready is high. A stalled m_ready holds the current word;
// the back end waits, input requests keep queueing until the queue fills.
// Synchronous active-low reset empties the queue, loads the initial hash
// values and clears the byte count; no clearing pass is needed.
module sha256_message_digest #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_byte_present,
    input  wire logic        s_end_of_message,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_last_word
);

    shamd_pkg::q_push_t q_push;
    shamd_pkg::q_head_t q_head;
    logic               q_full;
    logic               q_pop;

    shamd_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_byte_present   (s_byte_present),
        .s_end_of_message (s_end_of_message),
        .q_full           (q_full),
        .q_push           (q_push)
    );

    shamd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_pop   (q_pop),
        .q_full  (q_full),
        .q_head  (q_head)
    );

    shamd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

endmodule

`default_nettype wire
